### sv/ssalu_pkg.sv
package ssalu_pkg;

    // Operation codes, in instruction-set order
    typedef enum logic [4:0] {
        OP_ADD    = 5'd0,
        OP_ADDI   = 5'd1,
        OP_ADDIU  = 5'd2,
        OP_ADDU   = 5'd3,
        OP_DADD   = 5'd4,
        OP_DADDI  = 5'd5,
        OP_DADDIU = 5'd6,
        OP_DADDU  = 5'd7,
        OP_DSUB   = 5'd8,
        OP_DSUBU  = 5'd9,
        OP_SUB    = 5'd10,
        OP_SUBU   = 5'd11,
        OP_PADDB  = 5'd12,
        OP_PADDH  = 5'd13,
        OP_PADDSB = 5'd14,
        OP_PADDSH = 5'd15,
        OP_PADDSW = 5'd16,
        OP_PADDUB = 5'd17,
        OP_PADDUH = 5'd18,
        OP_PADDUW = 5'd19,
        OP_PADDW  = 5'd20,
        OP_PADSBH = 5'd21,
        OP_PSUBB  = 5'd22,
        OP_PSUBH  = 5'd23,
        OP_PSUBSB = 5'd24,
        OP_PSUBSH = 5'd25,
        OP_PSUBSW = 5'd26,
        OP_PSUBUB = 5'd27,
        OP_PSUBUH = 5'd28,
        OP_PSUBUW = 5'd29,
        OP_PSUBW  = 5'd30
    } op_e;

    localparam int unsigned LaneCount = 4;
    localparam int unsigned LaneBits  = 32;

    typedef enum logic [1:0] {
        CLS_NONE,
        CLS_S32,
        CLS_S64,
        CLS_PAR
    } op_class_e;

    typedef enum logic [1:0] {
        ELEM_W8,
        ELEM_W16,
        ELEM_W32
    } elem_width_e;

    typedef enum logic [1:0] {
        SAT_WRAP,
        SAT_SIGNED,
        SAT_UNSIGNED
    } sat_mode_e;

    typedef struct packed {
        logic [4:0]         operation;
        logic [63:0]        rs_low;
        logic [63:0]        rs_high;
        logic [63:0]        rt_low;
        logic [63:0]        rt_high;
        logic signed [15:0] immediate;
    } request_t;

    typedef struct packed {
        logic [63:0] result_low;
        logic [63:0] result_high;
        logic        high_written;
        logic        overflow_trap;
    } result_t;

    // Per-lane control for the parallel datapath
    typedef struct packed {
        elem_width_e width;
        sat_mode_e   mode;
        logic        sub;
    } lane_ctrl_t;

    // Control for the scalar datapath
    typedef struct packed {
        logic is64;
        logic use_imm;
        logic sub;
        logic traps;
    } scalar_ctrl_t;

    typedef struct packed {
        op_class_e    cls;
        elem_width_e  width;
        sat_mode_e    mode;
        logic         sub;
        logic         adsb;
        scalar_ctrl_t scalar;
    } op_ctrl_t;

    function automatic op_ctrl_t decode(logic [4:0] op);
        op_ctrl_t c;
        c = '{cls: CLS_NONE, width: ELEM_W8, mode: SAT_WRAP, sub: 1'b0, adsb: 1'b0,
              scalar: '0};
        case (op)
            OP_ADD:    begin c.cls = CLS_S32; c.scalar.traps = 1'b1; end
            OP_ADDI:   begin c.cls = CLS_S32; c.scalar.traps = 1'b1;
                             c.scalar.use_imm = 1'b1; end
            OP_ADDIU:  begin c.cls = CLS_S32; c.scalar.use_imm = 1'b1; end
            OP_ADDU:   c.cls = CLS_S32;
            OP_DADD:   begin c.cls = CLS_S64; c.scalar.traps = 1'b1; end
            OP_DADDI:  begin c.cls = CLS_S64; c.scalar.traps = 1'b1;
                             c.scalar.use_imm = 1'b1; end
            OP_DADDIU: begin c.cls = CLS_S64; c.scalar.use_imm = 1'b1; end
            OP_DADDU:  c.cls = CLS_S64;
            OP_DSUB:   begin c.cls = CLS_S64; c.scalar.traps = 1'b1;
                             c.scalar.sub = 1'b1; end
            OP_DSUBU:  begin c.cls = CLS_S64; c.scalar.sub = 1'b1; end
            OP_SUB:    begin c.cls = CLS_S32; c.scalar.traps = 1'b1;
                             c.scalar.sub = 1'b1; end
            OP_SUBU:   begin c.cls = CLS_S32; c.scalar.sub = 1'b1; end
            OP_PADDB:  begin c.cls = CLS_PAR; c.width = ELEM_W8; end
            OP_PADDH:  begin c.cls = CLS_PAR; c.width = ELEM_W16; end
            OP_PADDSB: begin c.cls = CLS_PAR; c.width = ELEM_W8;  c.mode = SAT_SIGNED; end
            OP_PADDSH: begin c.cls = CLS_PAR; c.width = ELEM_W16; c.mode = SAT_SIGNED; end
            OP_PADDSW: begin c.cls = CLS_PAR; c.width = ELEM_W32; c.mode = SAT_SIGNED; end
            OP_PADDUB: begin c.cls = CLS_PAR; c.width = ELEM_W8;  c.mode = SAT_UNSIGNED; end
            OP_PADDUH: begin c.cls = CLS_PAR; c.width = ELEM_W16; c.mode = SAT_UNSIGNED; end
            OP_PADDUW: begin c.cls = CLS_PAR; c.width = ELEM_W32; c.mode = SAT_UNSIGNED; end
            OP_PADDW:  begin c.cls = CLS_PAR; c.width = ELEM_W32; end
            OP_PADSBH: begin c.cls = CLS_PAR; c.width = ELEM_W16; c.adsb = 1'b1; end
            OP_PSUBB:  begin c.cls = CLS_PAR; c.width = ELEM_W8;  c.sub = 1'b1; end
            OP_PSUBH:  begin c.cls = CLS_PAR; c.width = ELEM_W16; c.sub = 1'b1; end
            OP_PSUBSB: begin c.cls = CLS_PAR; c.width = ELEM_W8;  c.sub = 1'b1;
                             c.mode = SAT_SIGNED; end
            OP_PSUBSH: begin c.cls = CLS_PAR; c.width = ELEM_W16; c.sub = 1'b1;
                             c.mode = SAT_SIGNED; end
            OP_PSUBSW: begin c.cls = CLS_PAR; c.width = ELEM_W32; c.sub = 1'b1;
                             c.mode = SAT_SIGNED; end
            OP_PSUBUB: begin c.cls = CLS_PAR; c.width = ELEM_W8;  c.sub = 1'b1;
                             c.mode = SAT_UNSIGNED; end
            OP_PSUBUH: begin c.cls = CLS_PAR; c.width = ELEM_W16; c.sub = 1'b1;
                             c.mode = SAT_UNSIGNED; end
            OP_PSUBUW: begin c.cls = CLS_PAR; c.width = ELEM_W32; c.sub = 1'b1;
                             c.mode = SAT_UNSIGNED; end
            OP_PSUBW:  begin c.cls = CLS_PAR; c.width = ELEM_W32; c.sub = 1'b1; end
            default:   c.cls = CLS_NONE;
        endcase
        return c;
    endfunction

endpackage

### sv/ssalu_lane.sv
// One 32-bit slice of the parallel datapath: four bytes, two halfwords or one word.
module ssalu_lane (
    input  logic [ssalu_pkg::LaneBits-1:0] a,
    input  logic [ssalu_pkg::LaneBits-1:0] b,
    input  ssalu_pkg::lane_ctrl_t          ctrl,
    output logic [ssalu_pkg::LaneBits-1:0] result
);

    logic [31:0] res_b;
    logic [31:0] res_h;
    logic [31:0] res_w;

    always_comb
    begin
        logic [8:0]  s9;
        logic [7:0]  x8;
        logic [7:0]  y8;
        logic        ov8;
        res_b = '0;
        for (int i = 0; i < 4; i++)
        begin
            x8 = a[8*i +: 8];
            y8 = b[8*i +: 8];
            s9 = ctrl.sub ? ({1'b0, x8} - {1'b0, y8}) : ({1'b0, x8} + {1'b0, y8});
            ov8 = ((x8[7] ^ y8[7]) == ctrl.sub) && (s9[7] != x8[7]);
            case (ctrl.mode)
                ssalu_pkg::SAT_SIGNED:
                    res_b[8*i +: 8] = ov8 ? {x8[7], {7{~x8[7]}}} : s9[7:0];
                ssalu_pkg::SAT_UNSIGNED:
                    res_b[8*i +: 8] = s9[8] ? {8{~ctrl.sub}} : s9[7:0];
                default:
                    res_b[8*i +: 8] = s9[7:0];
            endcase
        end
    end

    always_comb
    begin
        logic [16:0] s17;
        logic [15:0] x16;
        logic [15:0] y16;
        logic        ov16;
        res_h = '0;
        for (int i = 0; i < 2; i++)
        begin
            x16 = a[16*i +: 16];
            y16 = b[16*i +: 16];
            s17 = ctrl.sub ? ({1'b0, x16} - {1'b0, y16}) : ({1'b0, x16} + {1'b0, y16});
            ov16 = ((x16[15] ^ y16[15]) == ctrl.sub) && (s17[15] != x16[15]);
            case (ctrl.mode)
                ssalu_pkg::SAT_SIGNED:
                    res_h[16*i +: 16] = ov16 ? {x16[15], {15{~x16[15]}}} : s17[15:0];
                ssalu_pkg::SAT_UNSIGNED:
                    res_h[16*i +: 16] = s17[16] ? {16{~ctrl.sub}} : s17[15:0];
                default:
                    res_h[16*i +: 16] = s17[15:0];
            endcase
        end
    end

    always_comb
    begin
        logic [32:0] s33;
        logic        ov32;
        s33 = ctrl.sub ? ({1'b0, a} - {1'b0, b}) : ({1'b0, a} + {1'b0, b});
        ov32 = ((a[31] ^ b[31]) == ctrl.sub) && (s33[31] != a[31]);
        case (ctrl.mode)
            ssalu_pkg::SAT_SIGNED:   res_w = ov32 ? {a[31], {31{~a[31]}}} : s33[31:0];
            ssalu_pkg::SAT_UNSIGNED: res_w = s33[32] ? {32{~ctrl.sub}} : s33[31:0];
            default:                 res_w = s33[31:0];
        endcase
    end

    always_comb
    begin
        case (ctrl.width)
            ssalu_pkg::ELEM_W8:  result = res_b;
            ssalu_pkg::ELEM_W16: result = res_h;
            ssalu_pkg::ELEM_W32: result = res_w;
            default:             result = '0;
        endcase
    end

endmodule

### sv/ssalu_scalar.sv
// Scalar 32/64-bit add and subtract with signed overflow detection.
module ssalu_scalar (
    input  logic [63:0]             rs,
    input  logic [63:0]             rt,
    input  logic signed [15:0]      immediate,
    input  ssalu_pkg::scalar_ctrl_t ctrl,
    output logic [63:0]             result,
    output logic                    trap
);

    logic [63:0] op_a;
    logic [63:0] op_b;
    logic [63:0] sum;
    logic        ovf;

    // 32-bit forms run on sign-extended operands, so the 64-bit sum is exact
    always_comb
    begin
        op_a = ctrl.is64 ? rs : {{32{rs[31]}}, rs[31:0]};
        if (ctrl.use_imm)
            op_b = {{48{immediate[15]}}, immediate};
        else
            op_b = ctrl.is64 ? rt : {{32{rt[31]}}, rt[31:0]};
        sum = ctrl.sub ? (op_a - op_b) : (op_a + op_b);
        if (ctrl.is64)
            ovf = ctrl.sub ? ((op_a[63] ^ op_b[63]) & (op_a[63] ^ sum[63]))
                           : ((op_a[63] ^ sum[63]) & (op_b[63] ^ sum[63]));
        else
            ovf = sum[32] ^ sum[31];
        trap = ctrl.traps & ovf;
        if (trap)
            result = '0;
        else
            result = ctrl.is64 ? sum : {{32{sum[31]}}, sum[31:0]};
    end

endmodule

### sv/simd_saturating_add_sub_alu.sv
// Channel  | Handshake                      | Payload
// ---------+--------------------------------+-------------------------------
// request  | request_valid / request_ready  | request (ssalu_pkg::request_t)
// result   | result_valid  / result_ready   | result  (ssalu_pkg::result_t)
//
// Every request is decoded and computed on the way in and lands in the
// result register at the accepting edge: one request per clock unless stalled.
// The result register is the only storage; reset clears its valid flag.
// request_ready stays high while the result register is empty or being taken,
// so a stall on the result side holds the register and back-pressures requests.
module simd_saturating_add_sub_alu (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                request_valid,
    output logic                request_ready,
    input  ssalu_pkg::request_t request,
    output logic                result_valid,
    input  logic                result_ready,
    output ssalu_pkg::result_t  result
);

    ssalu_pkg::op_ctrl_t     ctrl;
    ssalu_pkg::scalar_ctrl_t scalar_ctrl;
    logic [127:0]            rs_full;
    logic [127:0]            rt_full;
    logic [127:0]            par_res;
    logic [63:0]             scalar_res;
    logic                    scalar_trap;
    ssalu_pkg::result_t      result_next;
    ssalu_pkg::result_t      result_reg;
    logic                    result_valid_reg;
    logic                    result_valid_next;
    logic                    accept;

    assign ctrl    = ssalu_pkg::decode(request.operation);
    assign rs_full = {request.rs_high, request.rs_low};
    assign rt_full = {request.rt_high, request.rt_low};

    // Parallel lanes: each takes 32 bits of both sources.
    // For PADSBH the low two lanes (halfwords 0..3) subtract, the upper two add.
    for (genvar k = 0; k < ssalu_pkg::LaneCount; k++)
    begin : g_lane
        ssalu_pkg::lane_ctrl_t lane_ctrl;

        assign lane_ctrl.width = ctrl.width;
        assign lane_ctrl.mode  = ctrl.mode;
        assign lane_ctrl.sub   = ctrl.sub | (ctrl.adsb & (k < ssalu_pkg::LaneCount / 2));

        ssalu_lane u_lane (
            .a      (rs_full[k*ssalu_pkg::LaneBits +: ssalu_pkg::LaneBits]),
            .b      (rt_full[k*ssalu_pkg::LaneBits +: ssalu_pkg::LaneBits]),
            .ctrl   (lane_ctrl),
            .result (par_res[k*ssalu_pkg::LaneBits +: ssalu_pkg::LaneBits])
        );
    end

    always_comb
    begin
        scalar_ctrl      = ctrl.scalar;
        scalar_ctrl.is64 = (ctrl.cls == ssalu_pkg::CLS_S64);
    end

    ssalu_scalar u_scalar (
        .rs        (request.rs_low),
        .rt        (request.rt_low),
        .immediate (request.immediate),
        .ctrl      (scalar_ctrl),
        .result    (scalar_res),
        .trap      (scalar_trap)
    );

    // Merge: pick the parallel or scalar answer; an unused code gives all zeros
    always_comb
    begin
        result_next = '0;
        case (ctrl.cls)
            ssalu_pkg::CLS_PAR:
            begin
                result_next.result_low   = par_res[63:0];
                result_next.result_high  = par_res[127:64];
                result_next.high_written = 1'b1;
            end
            ssalu_pkg::CLS_S32, ssalu_pkg::CLS_S64:
            begin
                result_next.result_low    = scalar_res;
                result_next.overflow_trap = scalar_trap;
            end
            default:
                result_next = '0;
        endcase
    end

    // Take a new request whenever the result register is empty or draining
    assign request_ready = !result_valid_reg || result_ready;
    assign accept        = request_valid && request_ready;

    always_comb
    begin
        if (accept)
            result_valid_next = 1'b1;
        else if (result_ready)
            result_valid_next = 1'b0;
        else
            result_valid_next = result_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= result_valid_next;
    end

    // Payload needs no reset; load only on accept, hold otherwise
    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> result_valid)
        else $error("accepted request did not reach the result register");

    a_trap_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.overflow_trap) |->
            (result.result_low == '0 && !result.high_written))
        else $error("trapping result carries a destination value");

    a_high_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.high_written) |-> (result.result_high == '0))
        else $error("scalar result has a non-zero upper half");

endmodule
